@@ design/short_dir_entry_decode_macros.svh @@
// Assertion macros shared by the short directory entry decoder.
`ifndef SHORT_DIR_ENTRY_DECODE_MACROS_SVH
`define SHORT_DIR_ENTRY_DECODE_MACROS_SVH

// Implication checked on every rising edge of clk_i outside reset.
`define SDDE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define SDDE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ design/sdde_pkg.sv @@
// Types and constants of the short directory entry decoder.
package sdde_pkg;

  localparam int unsigned EntryBytes = 32;
  localparam int unsigned PosW       = $clog2(EntryBytes);
  localparam int unsigned NameLen    = 11;
  localparam int unsigned BaseLen    = 8;
  localparam int unsigned ExtLen     = 3;

  localparam logic [PosW-1:0] PosAttr    = PosW'(11);
  localparam logic [PosW-1:0] PosClusHi0 = PosW'(20);
  localparam logic [PosW-1:0] PosClusHi1 = PosW'(21);
  localparam logic [PosW-1:0] PosClusLo0 = PosW'(26);
  localparam logic [PosW-1:0] PosClusLo1 = PosW'(27);
  localparam logic [PosW-1:0] PosSize0   = PosW'(28);
  localparam logic [PosW-1:0] PosSize1   = PosW'(29);
  localparam logic [PosW-1:0] PosSize2   = PosW'(30);
  localparam logic [PosW-1:0] PosLast    = PosW'(EntryBytes - 1);

  localparam logic [7:0] ChrSpace   = 8'h20;
  localparam logic [7:0] ChrDot     = 8'h2E;
  localparam logic [7:0] ChrDeleted = 8'hE5;
  localparam logic [7:0] ChrEnd     = 8'h00;
  localparam logic [7:0] AttrLfn    = 8'h0F;
  localparam int unsigned AttrVolBit = 3;
  localparam int unsigned AttrDirBit = 4;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    KIND_END  = 2'd0,
    KIND_SKIP = 2'd1,
    KIND_USED = 2'd2
  } kind_e;

  // One classified entry handed from the front to the back.
  typedef struct packed {
    kind_e                   kind;
    logic [NameLen-1:0][7:0] name;
    logic [3:0]              base_len;
    logic [1:0]              ext_len;
    logic [31:0]             cluster;
    logic [31:0]             size;
    logic                    dir;
  } desc_t;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  name_char;
    logic        char_valid;
    logic [31:0] cluster;
    logic [31:0] size;
    logic        dir;
    logic        last;
  } res_t;

endpackage

@@ design/sdde_front.sv @@
// Byte intake: position count, field capture and entry classification.
module sdde_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  output logic           push_o,
  output sdde_pkg::desc_t push_desc_o,
  input  logic           q_full_i
);
  import sdde_pkg::*;

  logic [PosW-1:0]         pos_q, pos_d;
  logic [NameLen-1:0][7:0] name_q;
  logic [7:0]              attr_q;
  logic [15:0]             clus_hi_q;
  logic [15:0]             clus_lo_q;
  logic [23:0]             size_q;
  logic                    accept;
  logic                    at_last;
  logic [3:0]              base_len;
  logic [1:0]              ext_len;

  assign at_last    = (pos_q == PosLast);
  // Only the closing byte needs a free queue slot.
  assign in_ready_o = !at_last || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_d      = pos_q + PosW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (pos_q < PosW'(NameLen)) begin
        name_q[pos_q[3:0]] <= in_byte_i;
      end
      case (pos_q)
        PosAttr:    attr_q          <= in_byte_i;
        PosClusHi0: clus_hi_q[7:0]  <= in_byte_i;
        PosClusHi1: clus_hi_q[15:8] <= in_byte_i;
        PosClusLo0: clus_lo_q[7:0]  <= in_byte_i;
        PosClusLo1: clus_lo_q[15:8] <= in_byte_i;
        PosSize0:   size_q[7:0]     <= in_byte_i;
        PosSize1:   size_q[15:8]    <= in_byte_i;
        PosSize2:   size_q[23:16]   <= in_byte_i;
        default:    ;
      endcase
    end
  end

  // Trailing-space trim: length is one past the last non-space character.
  always_comb begin
    base_len = '0;
    for (int i = 0; i < BaseLen; i++) begin
      if (name_q[i] != ChrSpace) base_len = 4'(i + 1);
    end
    ext_len = '0;
    for (int i = 0; i < ExtLen; i++) begin
      if (name_q[BaseLen + i] != ChrSpace) ext_len = 2'(i + 1);
    end
  end

  always_comb begin
    push_desc_o.name     = name_q;
    push_desc_o.base_len = base_len;
    push_desc_o.ext_len  = ext_len;
    push_desc_o.cluster  = {clus_hi_q, clus_lo_q};
    push_desc_o.size     = {in_byte_i, size_q};
    push_desc_o.dir      = attr_q[AttrDirBit];
    if (name_q[0] == ChrEnd) begin
      push_desc_o.kind = KIND_END;
    end else if (name_q[0] == ChrDeleted || attr_q == AttrLfn || attr_q[AttrVolBit]) begin
      push_desc_o.kind = KIND_SKIP;
    end else begin
      push_desc_o.kind = KIND_USED;
    end
  end

  assign push_o = accept && at_last;

endmodule

@@ design/sdde_queue.sv @@
// Short queue of classified entries between front and back.
module sdde_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sdde_pkg::desc_t push_desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sdde_pkg::desc_t head_o
);
  import sdde_pkg::*;

  `include "short_dir_entry_decode_macros.svh"

  desc_t             slot_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_desc_i;
  end

  `SDDE_ASSERT_NEVER(a_no_overflow, push_i && full_o, "queue push while full")
  `SDDE_ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "queue pop while empty")
  `SDDE_ASSERT_IMPL(a_cnt_tracks, push_i && !pop_i && !full_o, ##1 !empty_o,
                    "queue not occupied after push")

endmodule

@@ design/sdde_back.sv @@
// Result sequencer: walks a classified entry and drives the output register.
module sdde_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  sdde_pkg::desc_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sdde_pkg::res_t  out_res_o
);
  import sdde_pkg::*;

  `include "short_dir_entry_decode_macros.svh"

  logic [3:0] step_q;
  logic       out_valid_q;
  res_t       out_q, cur;
  logic       load;
  logic [3:0] ext_off;
  logic [7:0] ext_char;

  assign ext_off = step_q - head_i.base_len - 4'd1;

  always_comb begin
    case (ext_off[1:0])
      2'd0:    ext_char = head_i.name[BaseLen];
      2'd1:    ext_char = head_i.name[BaseLen + 1];
      default: ext_char = head_i.name[BaseLen + 2];
    endcase
  end

  always_comb begin
    cur            = '0;
    cur.kind       = head_i.kind;
    if (head_i.kind != KIND_USED) begin
      cur.last = 1'b1;
    end else if (step_q < head_i.base_len) begin
      cur.name_char  = head_i.name[step_q];
      cur.char_valid = 1'b1;
    end else if (head_i.ext_len != '0 && step_q == head_i.base_len) begin
      cur.name_char  = ChrDot;
      cur.char_valid = 1'b1;
    end else if (head_i.ext_len != '0 &&
                 step_q <= head_i.base_len + 4'(head_i.ext_len)) begin
      cur.name_char  = ext_char;
      cur.char_valid = 1'b1;
    end else begin
      cur.cluster = head_i.cluster;
      cur.size    = head_i.size;
      cur.dir     = head_i.dir;
      cur.last    = 1'b1;
    end
  end

  assign load  = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && cur.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        step_q      <= cur.last ? '0 : step_q + 4'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= cur;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `SDDE_ASSERT_IMPL(a_mid_is_char, out_valid_q && !out_q.last,
                    out_q.char_valid && out_q.kind == KIND_USED,
                    "non-final result without a name character")
  `SDDE_ASSERT_IMPL(a_step_bound, 1'b1, step_q <= 4'd12, "result step past 13 results")
  `SDDE_ASSERT_IMPL(a_step_zero_pop, pop_o, ##1 step_q == '0,
                    "step not rewound after final result")

endmodule

@@ design/short_dir_entry_decode.sv @@
// Top level of the short (8.3) directory entry decoder.
// Directory entries arrive as a byte stream, one byte per request, 32 bytes to an
// entry, and the decoder takes one byte every cycle with no gap between entries
// while the queue has room. The front counts the byte position and captures name,
// attribute, cluster and size; on the closing byte it classifies the entry (end of
// directory, skip, or used, with trimmed name lengths) and pushes it into a
// two-entry queue. The back pops entries and emits one result per cycle unless the
// output stalls: a single result for end or skip, or for a used entry one per name
// character (dot only if an extension exists) and then a final result with cluster,
// size and directory flag, at most 13 results. Results leave through a registered
// output, so the back emits at most one result a cycle and the input side sees
// backpressure only on the closing byte of an entry while both queue slots are full.
module short_dir_entry_decode (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] raw_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [7:0] name_char, [39:8] start_cluster,
                                      // [71:40] file_size, [72] is_directory, rest 0
  output logic [2:0]  m_axis_tuser,   // [1:0] entry_kind, [2] char_valid
  output logic        m_axis_tlast    // last_of_entry
);
  import sdde_pkg::*;

  logic  push, q_full, q_empty, pop;
  desc_t push_desc, head;
  res_t  res;

  sdde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .push_o      (push),
    .push_desc_o (push_desc),
    .q_full_i    (q_full)
  );

  sdde_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  sdde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Pack the result: tdata lowest field first, zero fill to whole bytes.
  assign m_axis_tdata = {7'd0, res.dir, res.size, res.cluster, res.name_char};
  assign m_axis_tuser = {res.char_valid, res.kind};
  assign m_axis_tlast = res.last;

endmodule

@@ tb/sv/short_dir_entry_decode_test.sv @@
// Self-checking testbench for the short (8.3) directory entry decoder.
module short_dir_entry_decode_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sdde_pkg::*;

  // Longest stretch without any accepted request before the run is declared hung.
  // The deliberate output hold-off is the longest legal quiet stretch.
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned IdleLimit  = 4000;
  // Drain time after the last expected result has arrived.
  localparam int unsigned TailCycles = 20;

  // Predicts the decoder output from the accepted bytes and checks results in order.
  class dir_entry_scoreboard;
    logic [PosW-1:0] byte_pos;
    logic [7:0]      name [NameLen];
    logic [7:0]      attr;
    logic [15:0]     clus_hi;
    logic [15:0]     clus_lo;
    logic [31:0]     size;
    res_t            pending_results[$];
    int unsigned     errors;

    function new();
      byte_pos  = '0;
      errors    = 0;
    endfunction

    function void push(kind_e k, logic [7:0] c, logic v, logic [31:0] cl,
                       logic [31:0] sz, logic d, logic l);
      res_t r;
      r            = '0;
      r.kind       = k;
      r.name_char  = c;
      r.char_valid = v;
      r.cluster    = cl;
      r.size       = sz;
      r.dir        = d;
      r.last       = l;
      pending_results.push_back(r);
    endfunction

    // Closing byte: classify the gathered entry and queue its results.
    function void classify_entry();
      int base_n;
      int ext_n;
      base_n = BaseLen;
      ext_n  = ExtLen;
      if (name[0] == ChrEnd) begin
        push(KIND_END, 8'h00, 1'b0, '0, '0, 1'b0, 1'b1);
        return;
      end
      if (name[0] == ChrDeleted || attr == AttrLfn || attr[AttrVolBit]) begin
        push(KIND_SKIP, 8'h00, 1'b0, '0, '0, 1'b0, 1'b1);
        return;
      end
      // only trailing spaces are trimmed; inner spaces stay in the name
      while (base_n > 0 && name[base_n-1] == ChrSpace) base_n--;
      while (ext_n > 0 && name[BaseLen+ext_n-1] == ChrSpace) ext_n--;
      for (int i = 0; i < base_n; i++) push(KIND_USED, name[i], 1'b1, '0, '0, 1'b0, 1'b0);
      if (ext_n > 0) begin
        push(KIND_USED, ChrDot, 1'b1, '0, '0, 1'b0, 1'b0);
        for (int i = 0; i < ext_n; i++) begin
          push(KIND_USED, name[BaseLen+i], 1'b1, '0, '0, 1'b0, 1'b0);
        end
      end
      push(KIND_USED, 8'h00, 1'b0, {clus_hi, clus_lo}, size, attr[AttrDirBit], 1'b1);
    endfunction

    // One accepted input request.
    function void note_byte(logic [7:0] b);
      if (byte_pos < NameLen) begin
        name[byte_pos[3:0]] = b;
      end else begin
        case (byte_pos)
          PosAttr:    attr          = b;
          PosClusHi0: clus_hi[7:0]  = b;
          PosClusHi1: clus_hi[15:8] = b;
          PosClusLo0: clus_lo[7:0]  = b;
          PosClusLo1: clus_lo[15:8] = b;
          PosSize0:   size[7:0]     = b;
          PosSize1:   size[15:8]    = b;
          PosSize2:   size[23:16]   = b;
          PosLast:    size[31:24]   = b;
          default: ;
        endcase
      end
      if (byte_pos == PosLast) classify_entry();
      byte_pos = byte_pos + PosW'(1);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    // One accepted result request; pad holds the unused upper tdata bits.
    function void check_result(res_t got, logic [6:0] pad);
      res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) report("entry_kind", want.kind, got.kind);
      if (got.name_char !== want.name_char) report("name_char", want.name_char, got.name_char);
      if (got.char_valid !== want.char_valid) report("char_valid", want.char_valid, got.char_valid);
      if (got.cluster !== want.cluster) report("start_cluster", want.cluster, got.cluster);
      if (got.size !== want.size) report("file_size", want.size, got.size);
      if (got.dir !== want.dir) report("is_directory", want.dir, got.dir);
      if (got.last !== want.last) report("last_of_entry", want.last, got.last);
      if (pad !== 7'd0) report("tdata padding", 64'd0, pad);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  short_dir_entry_decode uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  dir_entry_scoreboard board = new();

  // Entry under construction, sent byte 0 first.
  logic [7:0]  entry_bytes [EntryBytes];
  int unsigned bytes_in   = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max    = 3;
  logic        hold_off   = 1'b0;
  int unsigned rx_mode    = 0;
  int unsigned rx_left    = 0;
  int unsigned rx_cycle   = 0;
  logic        rx_ready;
  int unsigned idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: any accepted request on either side restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("short_dir_entry_decode_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: check what was accepted at this edge, then choose the next
  // tready. The stall pattern switches at random between modes: always ready,
  // coin flip, one stall in four, or mostly stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_result('{kind:       kind_e'(m_axis_tuser[1:0]),
                             name_char:  m_axis_tdata[7:0],
                             char_valid: m_axis_tuser[2],
                             cluster:    m_axis_tdata[39:8],
                             size:       m_axis_tdata[71:40],
                             dir:        m_axis_tdata[72],
                             last:       m_axis_tlast},
                           m_axis_tdata[79:73]);
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      rx_cycle++;
      case (rx_mode)
        0: rx_ready = 1'b1;
        1: rx_ready = 1'($urandom_range(0, 1));
        2: rx_ready = (rx_cycle % 4) != 0;
        default: rx_ready = ($urandom_range(0, 4) == 0);
      endcase
      m_axis_tready <= rx_ready && !hold_off;
    end
  end

  // Long output hold-off after the first entry: the sender keeps offering
  // bytes, the decoder queue fills and s_axis_tready must drop.
  initial begin
    wait (bytes_in >= EntryBytes);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // One input request, sent in bursts of random length with random gaps.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_byte(b);
    burst_left--;
    bytes_in++;
  endtask

  task automatic send_entry();
    for (int i = 0; i < EntryBytes; i++) send_byte(entry_bytes[i]);
  endtask

  // Fill an entry: 11-character raw name, attribute, cluster and size, the
  // reserved and time stamp bytes random.
  function automatic void build_entry(string nm, logic [7:0] attr, logic [31:0] clus,
                                      logic [31:0] sz);
    for (int i = 0; i < EntryBytes; i++) entry_bytes[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < NameLen; i++) entry_bytes[i] = nm[i];
    entry_bytes[PosAttr]    = attr;
    entry_bytes[PosClusHi0] = clus[23:16];
    entry_bytes[PosClusHi1] = clus[31:24];
    entry_bytes[PosClusLo0] = clus[7:0];
    entry_bytes[PosClusLo1] = clus[15:8];
    entry_bytes[PosSize0]   = sz[7:0];
    entry_bytes[PosSize1]   = sz[15:8];
    entry_bytes[PosSize2]   = sz[23:16];
    entry_bytes[PosLast]    = sz[31:24];
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // inner space survives, trailing one does not
    build_entry("READ ME TXT", 8'h20, 32'h0000_0003, 32'h0000_1234);
    send_entry();
    // longest name and all-ones fields: 13 results, directory flag set
    build_entry("           ", 8'hF7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < NameLen; i++) entry_bytes[i] = 8'hFF;
    send_entry();
    // end of directory marker
    build_entry("           ", 8'h00, 32'h0, 32'h0);
    entry_bytes[0] = ChrEnd;
    send_entry();
    // volume label together with other attribute bits
    build_entry("VOL2    X  ", 8'hF8, 32'hFFFF_FFFF, 32'h0);
    send_entry();
    // all-space base, extension with a trailing space
    build_entry("        AB ", 8'h00, 32'h0001_0000, 32'h8000_0000);
    send_entry();
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("short_dir_entry_decode_test: done, clean");
    end else begin
      $display("short_dir_entry_decode_test: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/sdde_pkg.sv
design/sdde_front.sv
design/sdde_queue.sv
design/sdde_back.sv
design/short_dir_entry_decode.sv
tb/sv/short_dir_entry_decode_test.sv
